/* rtl/bgcd_pkg.sv */
// Shared constants and controller/datapath interface types for the binary GCD unit.
// No dependencies; imported by every module of the block.
package bgcd_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int FIELD_W       = 64;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef struct packed {
        logic load;
        logic shared_step;
        logic run_step;
        logic back_step;
        logic capture;
    } bgcd_cmd_t;

    typedef struct packed {
        logic zero_any;
        logic both_even;
        logic equal;
        logic k_zero;
    } bgcd_stat_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHARED = 5'b00010,
        S_RUN    = 5'b00100,
        S_BACK   = 5'b01000,
        S_DONE   = 5'b10000
    } bgcd_state_t;

endpackage

/* rtl/bgcd_dpath.sv */
// Datapath of the binary GCD unit: operand registers, shared-power counter, result register.
// Depends on bgcd_pkg; driven by bgcd_ctrl through bgcd_cmd_t.
module bgcd_dpath
    import bgcd_pkg::*;
(
    input  logic                     clk,
    input  logic [FIELD_W-1:0]       op_a,
    input  logic [FIELD_W-1:0]       op_b,
    input  bgcd_cmd_t                cmd,
    output bgcd_stat_t               stat,
    output logic [FIELD_W-1:0]       gcd_value
);

    logic [OPERAND_WIDTH-1:0] x_reg, x_next;
    logic [OPERAND_WIDTH-1:0] y_reg, y_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [OPERAND_WIDTH-1:0] result_reg, result_next;
    logic                     x_gt_y;
    logic [OPERAND_WIDTH-1:0] big, little, diff;

    assign x_gt_y = x_reg > y_reg;
    assign big    = x_gt_y ? x_reg : y_reg;
    assign little = x_gt_y ? y_reg : x_reg;
    assign diff   = big - little;

    assign stat.zero_any  = (x_reg == '0) || (y_reg == '0);
    assign stat.both_even = !x_reg[0] && !y_reg[0];
    assign stat.equal     = x_reg == y_reg;
    assign stat.k_zero    = k_reg == '0;

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        k_next      = k_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            x_next = op_a[OPERAND_WIDTH-1:0];
            y_next = op_b[OPERAND_WIDTH-1:0];
            k_next = '0;
        end
        else if (cmd.shared_step)
        begin
            if (stat.zero_any)
            begin
                // gcd with zero is the other operand
                x_next = x_reg | y_reg;
            end
            else if (stat.both_even)
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + CNT_W'(1);
            end
        end
        else if (cmd.run_step)
        begin
            if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_gt_y)
            begin
                // both odd: difference is even, drop one zero at once
                x_next = diff >> 1;
            end
            else
            begin
                y_next = diff >> 1;
            end
        end
        else if (cmd.back_step)
        begin
            x_next = x_reg << 1;
            k_next = k_reg - CNT_W'(1);
        end
        if (cmd.capture)
        begin
            result_next = x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign gcd_value = FIELD_W'(result_reg);

endmodule

/* rtl/bgcd_ctrl.sv */
// Controller of the binary GCD unit: sequencing state machine and output valid flag.
// Depends on bgcd_pkg; commands bgcd_dpath and reads its status.
module bgcd_ctrl
    import bgcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  bgcd_stat_t stat,
    output bgcd_cmd_t  cmd
);

    bgcd_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SHARED;
                end
            end
            S_SHARED:
            begin
                cmd.shared_step = 1'b1;
                if (stat.zero_any)
                begin
                    state_next = S_BACK;
                end
                else if (!stat.both_even)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.equal)
                begin
                    state_next = S_BACK;
                end
                else
                begin
                    cmd.run_step = 1'b1;
                end
            end
            S_BACK:
            begin
                if (stat.k_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.back_step = 1'b1;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/binary_gcd_unit.sv */
// Binary GCD unit: one operand pair in, its greatest common divisor out.
// Depends on bgcd_pkg, bgcd_ctrl and bgcd_dpath.
//
// One pair is worked on at a time. After a beat is taken, a shift-and-subtract
// loop advancing one bit per cycle runs: the common power of two k is stripped,
// the odd parts are reduced (one trailing zero or one subtract-and-halve per
// cycle, then a check that sees them equal), the shared power is restored, and
// the result is captured into the output register once it is free. The input
// reopens together with the result. The result sits in an output register, so
// the next pair is accepted while the previous result still waits for
// out_ready; only a finished pair whose result cannot be captured yet holds the
// input closed.
// gcd(0,b)=b, gcd(a,0)=a and gcd(0,0)=0.
module binary_gcd_unit
    import bgcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] op_a,
    input  logic [FIELD_W-1:0] op_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] gcd_value
);

    bgcd_cmd_t  cmd;
    bgcd_stat_t stat;

    bgcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bgcd_dpath u_dpath (
        .clk       (clk),
        .op_a      (op_a),
        .op_b      (op_b),
        .cmd       (cmd),
        .stat      (stat),
        .gcd_value (gcd_value)
    );

endmodule

/* rtl/binary_gcd_unit_checker.sv */
// Port-level checker for binary_gcd_unit, bound to the top level.
// Depends on bgcd_pkg for field widths.
module binary_gcd_unit_checker
    import bgcd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [FIELD_W-1:0] op_a,
    input logic [FIELD_W-1:0] op_b,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] gcd_value
);

    // a waiting operand beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op_a) && $stable(op_b))
        else $error("operand beat changed while waiting");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gcd_value))
        else $error("result beat changed while stalled");

    // one pair at a time: taking a beat closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after accepting a beat");

    // the input closes only by accepting a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && $past(in_ready) |-> $past(in_valid))
        else $error("input closed without a beat");

    // a fresh result comes with the input reopening
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && !$past(in_ready))
        else $error("result appeared without finishing a pair");

endmodule

bind binary_gcd_unit binary_gcd_unit_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op_a      (op_a),
    .op_b      (op_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gcd_value (gcd_value)
);
